@@ hdl/arx_pkg.sv @@
// ----------------------------------------------------------------------------
// arx_pkg: shared types and constants for the ARX/XOR byte stream cipher
// Register indexes, cipher mode codes, seed constant and sequencer controls.
// ----------------------------------------------------------------------------
`default_nettype none

package arx_pkg;

   localparam int WORD_W = 32;
   localparam int BYTE_W = 8;
   localparam int MODE_W = 2;
   localparam int KEY_HIGH_W = 24;
   localparam int CSR_INDEX_W = 2;

   localparam logic [BYTE_W-1:0] SEED_CONST = 8'h5A;

   localparam int ROT_B1 = 13;
   localparam int ROT_A1 = 16;
   localparam int ROT_A2 = 7;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CIPHER_MODE   = 2'd0,
      CSR_KEY_LOW_WORD  = 2'd1,
      CSR_KEY_HIGH_BITS = 2'd2
   } csr_index_type;

   typedef enum logic [MODE_W-1:0] {
      MODE_NONE    = 2'd0,
      MODE_XOR     = 2'd1,
      MODE_ARX     = 2'd2,
      MODE_INVALID = 2'd3
   } cipher_mode_type;

   typedef struct packed {
      logic load_seed;
      logic step_round;
      logic emit;
   } ctrl_type;

endpackage : arx_pkg

`default_nettype wire

@@ hdl/arx_round_unit.sv @@
// ----------------------------------------------------------------------------
// arx_round_unit: one add-rotate-xor keystream round
// a += b; b = rotl(b,13) ^ a; a = rotl(a,16); b += a; a = rotl(a,7).
// ----------------------------------------------------------------------------
`default_nettype none

module arx_round_unit
   import arx_pkg::*;
(
   input  wire logic [WORD_W-1:0] word_a,
   input  wire logic [WORD_W-1:0] word_b,
   output logic      [WORD_W-1:0] next_a,
   output logic      [WORD_W-1:0] next_b
);

   logic [WORD_W-1:0] a_sum;
   logic [WORD_W-1:0] b_mix;
   logic [WORD_W-1:0] a_rot;

   always_comb begin
      a_sum  = word_a + word_b;
      b_mix  = {word_b[WORD_W-ROT_B1-1:0], word_b[WORD_W-1:WORD_W-ROT_B1]} ^ a_sum;
      a_rot  = {a_sum[WORD_W-ROT_A1-1:0], a_sum[WORD_W-1:WORD_W-ROT_A1]};
      next_b = b_mix + a_rot;
      next_a = {a_rot[WORD_W-ROT_A2-1:0], a_rot[WORD_W-1:WORD_W-ROT_A2]};
   end

endmodule : arx_round_unit

`default_nettype wire

@@ hdl/arx_ctrl.sv @@
// ----------------------------------------------------------------------------
// arx_ctrl: sequencer for the shared round unit
// Accepts one byte, runs the warm-up rounds after a seed, then emits.
// ----------------------------------------------------------------------------
`default_nettype none

module arx_ctrl
   import arx_pkg::*;
#(
   parameter int WARMUP_ROUNDS = 8
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic accept,
   input  wire logic arx_mode,
   input  wire logic seeded,
   input  wire logic out_free,
   output logic      ready,
   output ctrl_type  ctrl
);

   localparam int CNT_W = $clog2(WARMUP_ROUNDS + 2);
   localparam logic [CNT_W-1:0] CNT_LOAD = CNT_W'(WARMUP_ROUNDS);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WARM,
      ST_EMIT
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      state_in        = state_ff;
      count_in        = count_ff;
      ready           = 1'b0;
      ctrl.load_seed  = 1'b0;
      ctrl.step_round = 1'b0;
      ctrl.emit       = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            ready = 1'b1;
            if (accept) begin
               count_in = CNT_LOAD;
               if (arx_mode && !seeded) begin
                  ctrl.load_seed = 1'b1;
                  state_in       = ST_WARM;
               end else begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_WARM: begin
            if (count_ff != '0) begin
               ctrl.step_round = 1'b1;
               count_in        = count_ff - 1'b1;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            // hold until the output register can take the transfer
            if (out_free) begin
               ctrl.emit       = 1'b1;
               ctrl.step_round = arx_mode;
               state_in        = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

endmodule : arx_ctrl

`default_nettype wire

@@ hdl/arx_xor_stream_cipher_unit.sv @@
// ----------------------------------------------------------------------------
// arx_xor_stream_cipher_unit: byte stream cipher, pass / xor / ARX keystream
//
// Bytes enter on the req_ stream (tdata = byte, tlast = end of buffer) and
// leave on the rsp_ stream, one result per byte, in order. The csr_ port
// writes cipher mode and key; write it only while no byte is in flight.
// In ARX mode the first byte of a buffer seeds the keystream words from the
// key and runs WARMUP_ROUNDS warm-up rounds through the single round unit,
// one round per cycle, before its own output round. A non-ARX or seeded
// ARX byte goes from accept through the emit state into the result
// register; a seeding byte first loads the seed and runs the warm-up
// rounds. A byte is emitted only once the output register is free.
// req_tready is high only while the sequencer is idle, so a new byte can be
// taken once the previous one has reached the output register. If the
// receiver stalls, the result holds in the output register, one more byte
// may be accepted and then waits.
// Reset clears the mode and key registers, the keystream words, the seeded
// flag and the output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module arx_xor_stream_cipher_unit
   import arx_pkg::*;
#(
   parameter int WARMUP_ROUNDS = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   // configuration write port
   input  wire logic             csr_we,
   input  wire logic [1:0]       csr_index,
   input  wire logic [31:0]      csr_wdata,
   // input stream
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   input  wire logic [7:0]       req_tdata,   // [7:0] data_in
   input  wire logic             req_tlast,   // last_byte
   // result stream
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   output logic      [7:0]       rsp_tdata,   // [7:0] data_out
   output logic                  rsp_tuser,   // mode_error
   output logic                  rsp_tlast    // end_of_buffer
);

   logic [MODE_W-1:0]     mode_ff;
   logic [WORD_W-1:0]     key_low_ff;
   logic [KEY_HIGH_W-1:0] key_high_ff;

   logic [WORD_W-1:0] word_a_ff, word_a_in;
   logic [WORD_W-1:0] word_b_ff, word_b_in;
   logic              seeded_ff, seeded_in;

   logic [BYTE_W-1:0] data_ff;
   logic              last_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] rsp_data_ff, rsp_data_in;
   logic              rsp_err_ff, rsp_err_in;
   logic              rsp_last_ff;

   logic [WORD_W-1:0] round_a;
   logic [WORD_W-1:0] round_b;
   logic              accept;
   logic              arx_mode;
   logic              out_free;
   ctrl_type          ctrl;

   assign accept   = req_tvalid && req_tready;
   assign arx_mode = (mode_ff == MODE_ARX);
   assign out_free = !rsp_valid_ff || rsp_tready;

   arx_round_unit u_round (
      .word_a (word_a_ff),
      .word_b (word_b_ff),
      .next_a (round_a),
      .next_b (round_b)
   );

   arx_ctrl #(
      .WARMUP_ROUNDS (WARMUP_ROUNDS)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .arx_mode (arx_mode),
      .seeded   (seeded_ff),
      .out_free (out_free),
      .ready    (req_tready),
      .ctrl     (ctrl)
   );

   always_comb begin
      word_a_in = word_a_ff;
      word_b_in = word_b_ff;
      if (ctrl.load_seed) begin
         word_a_in = key_low_ff;
         word_b_in = {SEED_CONST, key_high_ff};
      end else if (ctrl.step_round) begin
         word_a_in = round_a;
         word_b_in = round_b;
      end
   end

   always_comb begin
      seeded_in  = seeded_ff;
      rsp_data_in = rsp_data_ff;
      rsp_err_in  = rsp_err_ff;
      if (ctrl.emit) begin
         // end of buffer clears the seed in every mode
         seeded_in  = last_ff ? 1'b0 : (seeded_ff || arx_mode);
         rsp_err_in = 1'b0;
         unique case (mode_ff)
            MODE_NONE:    rsp_data_in = data_ff;
            MODE_XOR:     rsp_data_in = data_ff ^ key_low_ff[BYTE_W-1:0];
            MODE_ARX:     rsp_data_in = data_ff ^ round_b[BYTE_W-1:0];
            MODE_INVALID: begin
               rsp_data_in = data_ff;
               rsp_err_in  = 1'b1;
            end
            default:      rsp_data_in = data_ff;
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctrl.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_NONE;
         key_low_ff   <= '0;
         key_high_ff  <= '0;
         word_a_ff    <= '0;
         word_b_ff    <= '0;
         seeded_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_CIPHER_MODE:   mode_ff     <= csr_wdata[MODE_W-1:0];
               CSR_KEY_LOW_WORD:  key_low_ff  <= csr_wdata[WORD_W-1:0];
               CSR_KEY_HIGH_BITS: key_high_ff <= csr_wdata[KEY_HIGH_W-1:0];
               default: ;
            endcase
         end
         word_a_ff    <= word_a_in;
         word_b_ff    <= word_b_in;
         seeded_ff    <= seeded_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         data_ff <= req_tdata;
         last_ff <= req_tlast;
      end
      if (ctrl.emit) begin
         rsp_last_ff <= last_ff;
      end
      rsp_data_ff <= rsp_data_in;
      rsp_err_ff  <= rsp_err_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_err_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule : arx_xor_stream_cipher_unit

`default_nettype wire
